// ===== hdl/max_heap_priority_queue_defines.svh =====
// Assertion macros for the max-heap priority queue checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HMPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hmpq_pkg.sv =====
// Shared types and codes of the max-heap priority queue.
// Used by the channel payloads, the sequencer, the top level and the checker.
package hmpq_pkg;

	localparam int KEY_W = 32;
	localparam int OPC_W = 2;
	localparam int POS_W = 6;
	localparam int CAP_W = 7;
	localparam int STS_W = 2;
	localparam int CNT_W = 7;

	localparam logic [OPC_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OPC_W-1:0] OP_EXTRACT = 2'd1;
	localparam logic [OPC_W-1:0] OP_CHANGE  = 2'd2;

	localparam logic [STS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STS_W-1:0] ST_RANGE = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		key_t             key_value;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		key_t             extracted_key;
		key_t             top_key;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity_limit;
	} cfg_t;

endpackage

// ===== hdl/hmpq_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// The payload type is set per instance (request, result or configuration).
interface hmpq_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/hmpq_cmp.sv =====
// Shared signed key comparator used by every sift step.
// Depends on hmpq_pkg for the key type.
module hmpq_cmp import hmpq_pkg::*; (
	input  key_t a,
	input  key_t b,
	output logic lt,
	output logic eq
);
	assign lt = (a < b);
	assign eq = (a == b);
endmodule

// ===== hdl/hmpq_store.sv =====
// Heap entry store: one write port and one read port with registered data.
// Depends on hmpq_pkg for the key type.
module hmpq_store import hmpq_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  key_t          wdata,
	input  logic [AW-1:0] raddr,
	output key_t          rdata
);
	key_t heap_q [DEPTH];
	key_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			heap_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= heap_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/hmpq_ctrl.sv =====
// Sequencer that runs insert, extract and change-priority over the store.
// Depends on hmpq_pkg and instantiates the shared comparator hmpq_cmp.
module hmpq_ctrl import hmpq_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  req_t             in_item,
	output logic             in_ready,
	input  logic [CAP_W-1:0] cap,
	input  logic             res_free,
	output logic             done,
	output rsp_t             result,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output key_t             mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  key_t             mem_rdata
);
	localparam int XW = AW + 2;
	localparam int WW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_LAST_RD = 10'b00_0000_0010,
		S_CH_CMP  = 10'b00_0000_0100,
		S_UP_RD   = 10'b00_0000_1000,
		S_UP_CMP  = 10'b00_0001_0000,
		S_DN_RDL  = 10'b00_0010_0000,
		S_DN_RDR  = 10'b00_0100_0000,
		S_DN_CMPR = 10'b00_1000_0000,
		S_DN_WR   = 10'b01_0000_0000,
		S_FINISH  = 10'b10_0000_0000
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    best_idx_q;
	logic             moved_q;
	key_t             key_q;
	key_t             best_val_q;
	key_t             top_q;
	key_t             ext_q;
	logic [STS_W-1:0] st_q;

	logic [CW-1:0] cnt_dec;
	logic [AW-1:0] parent;
	logic [XW-1:0] left;
	logic [XW-1:0] right;
	logic          left_in;
	logic          right_in;
	logic          full;
	logic          pos_out;
	key_t          cmp_a;
	key_t          cmp_b;
	logic          lt;
	logic          eq;

	assign cnt_dec  = count_q - CW'(1);
	assign parent   = AW'(idx_q - AW'(1)) >> 1;
	assign left     = XW'({idx_q, 1'b1});
	assign right    = left + XW'(1);
	assign left_in  = (left < XW'(count_q));
	assign right_in = (right < XW'(count_q));
	assign full     = (WW'(count_q) >= WW'(cap)) || (count_q >= CW'(DEPTH));
	assign pos_out  = (WW'(in_item.position) >= WW'(count_q));

	// Operand selection for the one comparator.
	always_comb begin
		cmp_a = key_q;
		cmp_b = mem_rdata;
		if (state_q == S_CH_CMP || state_q == S_UP_CMP) begin
			cmp_a = mem_rdata;
			cmp_b = key_q;
		end else if (state_q == S_DN_CMPR) begin
			cmp_a = best_val_q;
		end
	end

	hmpq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt),
		.eq (eq)
	);

	// The sifted key rides in key_q; displaced entries are written into the hole.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = key_q;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_item.opcode == OP_EXTRACT) begin
					mem_raddr = cnt_dec[AW-1:0];
				end else begin
					mem_raddr = AW'(in_item.position);
				end
			end
			S_UP_RD: begin
				mem_raddr = parent;
				mem_we    = (idx_q == '0);
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (lt) begin
					mem_wdata = mem_rdata;
				end
			end
			S_DN_RDL: begin
				mem_raddr = left[AW-1:0];
				mem_we    = !left_in;
			end
			S_DN_RDR: begin
				mem_raddr = right[AW-1:0];
			end
			S_DN_WR: begin
				mem_we = 1'b1;
				if (moved_q) begin
					mem_wdata = best_val_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q <= in_item.key_value;
						unique case (in_item.opcode)
							OP_INSERT: begin
								ext_q <= '0;
								if (full) begin
									st_q    <= ST_FULL;
									state_q <= S_FINISH;
								end else begin
									st_q    <= ST_OK;
									idx_q   <= count_q[AW-1:0];
									count_q <= count_q + CW'(1);
									state_q <= S_UP_RD;
								end
							end
							OP_EXTRACT: begin
								if (count_q == '0) begin
									st_q    <= ST_EMPTY;
									ext_q   <= '0;
									state_q <= S_FINISH;
								end else begin
									st_q    <= ST_OK;
									ext_q   <= top_q;
									count_q <= cnt_dec;
									idx_q   <= '0;
									state_q <= (cnt_dec == '0) ? S_FINISH : S_LAST_RD;
								end
							end
							OP_CHANGE: begin
								ext_q <= '0;
								if (pos_out) begin
									st_q    <= ST_RANGE;
									state_q <= S_FINISH;
								end else begin
									st_q    <= ST_OK;
									idx_q   <= AW'(in_item.position);
									state_q <= S_CH_CMP;
								end
							end
							default: begin
								st_q    <= ST_OK;
								ext_q   <= '0;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_LAST_RD: begin
					key_q   <= mem_rdata;
					state_q <= S_DN_RDL;
				end
				S_CH_CMP: begin
					if (lt) begin
						state_q <= S_UP_RD;
					end else if (eq) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_DN_RDL;
					end
				end
				S_UP_RD: begin
					state_q <= (idx_q == '0) ? S_FINISH : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (lt) begin
						idx_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DN_RDL: begin
					state_q <= left_in ? S_DN_RDR : S_FINISH;
				end
				S_DN_RDR: begin
					if (lt) begin
						best_val_q <= mem_rdata;
						best_idx_q <= left[AW-1:0];
						moved_q    <= 1'b1;
					end else begin
						best_val_q <= key_q;
						moved_q    <= 1'b0;
					end
					state_q <= right_in ? S_DN_CMPR : S_DN_WR;
				end
				S_DN_CMPR: begin
					if (lt) begin
						best_val_q <= mem_rdata;
						best_idx_q <= right[AW-1:0];
						moved_q    <= 1'b1;
					end
					state_q <= S_DN_WR;
				end
				S_DN_WR: begin
					if (moved_q) begin
						idx_q   <= best_idx_q;
						state_q <= S_DN_RDL;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Copy of the root so that results and extracts need no extra read.
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			top_q <= mem_wdata;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign done     = (state_q == S_FINISH) && res_free;

	assign result.status        = st_q;
	assign result.extracted_key = ext_q;
	assign result.top_key       = (count_q != '0) ? top_q : key_t'(0);
	assign result.entry_count   = CNT_W'(count_q);
endmodule

// ===== hdl/max_heap_priority_queue.sv =====
// Channel   Modport  Payload  Moves per transfer
// req       sink     req_t    one operation: opcode, key_value, position
// rsp       source   rsp_t    one result: status, extracted_key, top_key, entry_count
// cfg       sink     cfg_t    new capacity_limit, always ready
//
// An operation keeps req low from its transfer until its result moves to the output
// register. A refused operation or the spare opcode goes straight to its result; a sift
// climbs or sinks one level at a time and is longest for a new root key sinking to the
// last entry. The single read port of the store, with its registered data, sets the
// length of each level. The store holds no reset state, so no clearing pass follows
// reset; a stalled rsp holds the next result in the sequencer.
module max_heap_priority_queue import hmpq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	hmpq_chan_if.sink     req,
	hmpq_chan_if.source   rsp,
	hmpq_chan_if.sink     cfg
);
	localparam int AW = $clog2(DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic             rsp_valid_q;
	rsp_t             rsp_data_q;
	logic             res_free;
	logic             done;
	rsp_t             result;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	key_t             mem_wdata;
	logic [AW-1:0]    mem_raddr;
	key_t             mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data.capacity_limit;
		end
	end

	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
			rsp_data_q  <= result;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	hmpq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_item   (req.data),
		.in_ready  (req.ready),
		.cap       (cap_q),
		.res_free  (res_free),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	hmpq_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule

// ===== hdl/hmpq_checker.sv =====
// Port-level checks of the max-heap priority queue, bound to the top level.
// Depends on hmpq_pkg and the macros in max_heap_priority_queue_defines.svh.
`include "max_heap_priority_queue_defines.svh"

module hmpq_port_checker import hmpq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hmpq_chan_if.sink   req,
	hmpq_chan_if.source rsp
);
	logic req_xfer;
	logic rsp_held;
	logic rsp_empty;
	logic rsp_none;
	logic rsp_no_key;

	assign req_xfer   = req.valid && req.ready;
	assign rsp_held   = rsp.valid && !rsp.ready;
	assign rsp_empty  = rsp.valid && (rsp.data.status == ST_EMPTY);
	assign rsp_none   = rsp.valid && (rsp.data.entry_count == '0);
	assign rsp_no_key = (rsp.data.extracted_key == '0);

	// A result waiting on a stalled sink keeps its value.
	`HMPQ_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp.valid && $stable(rsp.data), "rsp changed while held")

	// Each operation leaves the idle state after its transfer, so no back-to-back request transfers.
	`HMPQ_ASSERT_NEXT(a_req_gap, req_xfer, !req.ready, "request taken in two consecutive cycles")

	// An empty report means nothing is stored and nothing was removed.
	`HMPQ_ASSERT_SAME(a_empty_rsp, rsp_empty, rsp_none && rsp_no_key, "empty status with data")

	// An empty heap reports a zero top.
	`HMPQ_ASSERT_SAME(a_zero_top, rsp_none, rsp.data.top_key == '0, "nonzero top on an empty heap")
endmodule

bind max_heap_priority_queue hmpq_port_checker u_hmpq_port_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
